@@ hdl/pvs_zero_run_decompress_top_macros.svh @@
// Assertion macros shared by the zero-run decompressor RTL.
`ifndef PVS_ZERO_RUN_DECOMPRESS_TOP_MACROS_SVH
`define PVS_ZERO_RUN_DECOMPRESS_TOP_MACROS_SVH

// Implication checked on every rising edge of clk, idle while rst_n is low.
`define PVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, with the consequent taken in the cycle after the antecedent.
`define PVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pvszr_pkg.sv @@
// Shared constants and types for the zero-run visibility decompressor.
package pvszr_pkg;

    localparam int CFG_W           = 11;
    localparam int BYTE_W          = 8;
    localparam int WORD_BYTES      = 8;
    localparam int WORD_W          = WORD_BYTES * BYTE_W;
    localparam int FILL_W          = 3;
    localparam int COUNT_W         = 4;
    localparam int OUT_TDATA_W     = 72;
    localparam int MAX_ROW_BYTES_DEF = 1024;

    localparam logic [CFG_W-1:0] ROW_BYTES_RST = CFG_W'(1024);

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

@@ hdl/pvs_zero_run_decompress_top.sv @@
// Zero-run visibility row decompressor: compressed bytes in, packed 64-bit words out.
// Literal, marker and count bytes are each taken as one request while idle and the output register can take a word.
// A zero run is then expanded by the single shared push unit at one output word chunk per cycle (up to 33 chunks)
// while the output register can take a word; no further request is taken on the input meanwhile.
// Reset (rst_n low, asynchronous) clears the row state and loads row_bytes with 1024.
`include "pvs_zero_run_decompress_top_macros.svh"

module pvs_zero_run_decompress_top #(
    parameter int MAX_ROW_BYTES = pvszr_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel: row_bytes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  pvszr_pkg::cfg_t                cfg_data,
    // Compressed input. tdata: in_byte [7:0].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  pvszr_pkg::byte_t               s_axis_tdata,
    // Decompressed output. tdata: vis_word [63:0], byte_count [67:64], zero pad [71:68].
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pvszr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // last_of_row.
    output logic                           m_axis_tlast
);
    import pvszr_pkg::*;

    // Row counter width follows the largest row the block supports.
    localparam int RW = $clog2(MAX_ROW_BYTES + 1);
    // Width used for comparing the configured length against the limit.
    localparam int CW = (RW > CFG_W) ? RW : CFG_W;
    // Width used for comparing the chunk size with the row remainder.
    localparam int KW = (RW > BYTE_W) ? RW : BYTE_W;

    // Sequencer: IDLE takes input requests, RUN expands a zero run chunk by chunk.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                state_reg, state_next;
    logic                count_pending_reg, count_pending_next;
    word_t               accum_reg, accum_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [RW-1:0]       row_done_reg, row_done_next;
    byte_t               run_left_reg, run_left_next;
    cfg_t                row_bytes_reg;

    // Output holding register: one finished word waits here for the sink.
    logic                out_valid_reg, out_valid_next;
    word_t               out_word_reg;
    count_t              out_count_reg;
    logic                out_last_reg;

    logic                slot_free;
    logic                in_accept;
    logic                lit_go;
    logic                step_go;

    // Push unit signals.
    logic [CW-1:0]       row_ext;
    logic [CW-1:0]       eff_c;
    logic [RW-1:0]       eff_row;
    logic [RW-1:0]       rem;
    logic [COUNT_W-1:0]  avail;
    byte_t               want;
    logic [COUNT_W-1:0]  k;
    logic [COUNT_W-1:0]  fill_sum;
    logic                row_end;
    logic                emit;
    word_t               ins;
    word_t               merged;
    byte_t               run_after;

    // Configuration is taken at any time; the host must write only while idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_bytes_reg <= cfg_data;
        end
    end

    // The push unit may only run when the output register can take its word.
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign lit_go        = in_accept && !count_pending_reg && (s_axis_tdata != '0);
    assign step_go       = lit_go || ((state_reg == ST_RUN) && slot_free);

    // Effective row length: zero acts as one, anything above the limit is clipped.
    always_comb
    begin
        row_ext = CW'(row_bytes_reg);
        if (row_ext == '0)
        begin
            eff_c = CW'(1);
        end
        else if (row_ext > CW'(MAX_ROW_BYTES))
        begin
            eff_c = CW'(MAX_ROW_BYTES);
        end
        else
        begin
            eff_c = row_ext;
        end
        eff_row = eff_c[RW-1:0];
    end

    // Shared push unit. It places a literal, or the largest run chunk that fits
    // in the current word, the run and the row, all in one step. If the row
    // counter has already reached the length (a shorter length written mid-row),
    // the row closes after the next byte.
    always_comb
    begin
        if (row_done_reg < eff_row)
        begin
            rem = eff_row - row_done_reg;
        end
        else
        begin
            rem = RW'(1);
        end
        avail = COUNT_W'(WORD_BYTES) - COUNT_W'(fill_reg);
        want  = (state_reg == ST_RUN) ? run_left_reg : BYTE_W'(1);
        k     = avail;
        if (BYTE_W'(k) > want)
        begin
            k = want[COUNT_W-1:0];
        end
        if (KW'(k) > KW'(rem))
        begin
            k = COUNT_W'(rem);
        end
        fill_sum  = COUNT_W'(fill_reg) + k;
        row_end   = (KW'(k) == KW'(rem));
        emit      = fill_sum[COUNT_W-1] || row_end;
        ins       = (state_reg == ST_RUN) ? '0
                    : (WORD_W'(s_axis_tdata) << {fill_reg, 3'b000});
        merged    = accum_reg | ins;
        run_after = run_left_reg - BYTE_W'(k);
    end

    // Sequencer and row state.
    always_comb
    begin
        state_next         = state_reg;
        count_pending_next = count_pending_reg;
        accum_next         = accum_reg;
        fill_next          = fill_reg;
        row_done_next      = row_done_reg;
        run_left_next      = run_left_reg;

        if (in_accept)
        begin
            if (count_pending_reg)
            begin
                // Count byte after a marker: a zero count gives no bytes.
                count_pending_next = 1'b0;
                run_left_next      = s_axis_tdata;
                if (s_axis_tdata != '0)
                begin
                    state_next = ST_RUN;
                end
            end
            else if (s_axis_tdata == '0)
            begin
                count_pending_next = 1'b1;
            end
        end

        if (step_go)
        begin
            if (emit)
            begin
                accum_next = '0;
                fill_next  = '0;
            end
            else
            begin
                accum_next = merged;
                fill_next  = fill_sum[FILL_W-1:0];
            end
            if (row_end)
            begin
                row_done_next      = '0;
                count_pending_next = 1'b0;
            end
            else
            begin
                row_done_next = row_done_reg + RW'(k);
            end
            if (state_reg == ST_RUN)
            begin
                run_left_next = run_after;
                // The excess of a run that reaches the row end is dropped.
                if (row_end || (run_after == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_pending_reg <= 1'b0;
            accum_reg         <= '0;
            fill_reg          <= '0;
            row_done_reg      <= '0;
            run_left_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_pending_reg <= count_pending_next;
            accum_reg         <= accum_next;
            fill_reg          <= fill_next;
            row_done_reg      <= row_done_next;
            run_left_reg      <= run_left_next;
        end
    end

    // Output register: loaded by the push unit, cleared when the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && emit)
        begin
            out_word_reg  <= merged;
            out_count_reg <= fill_sum;
            out_last_reg  <= row_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - COUNT_W)'(0), out_count_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

    // A word leaves with between one and eight bytes.
    `PVS_ASSERT(a_count_range,
        m_axis_tvalid |-> ((out_count_reg != '0) && (out_count_reg <= COUNT_W'(WORD_BYTES))),
        "byte count out of range")
    // Only the closing word of a row may be short.
    `PVS_ASSERT(a_short_is_last,
        (m_axis_tvalid && !out_last_reg) |-> (out_count_reg == COUNT_W'(WORD_BYTES)),
        "short word not at row end")
    // The run sequencer always has zeros left to place and no marker pending.
    `PVS_ASSERT(a_run_left,
        (state_reg == ST_RUN) |-> ((run_left_reg != '0) && !count_pending_reg),
        "run state without work")
    // A nonzero count byte starts the run sequencer.
    `PVS_ASSERT_NEXT(a_run_start,
        in_accept && count_pending_reg && (s_axis_tdata != '0), state_reg == ST_RUN,
        "count byte did not start a run")

endmodule

@@ test/pvs_vis_checker.sv @@
// Checker for the zero-run decompressor: predicts packed words from accepted requests and compares.
module pvs_vis_checker #(
    parameter int MAX_ROW = pvszr_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  pvszr_pkg::cfg_t                   cfg_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  pvszr_pkg::byte_t                  s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [pvszr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                              m_axis_tlast,
    output int                                errors,
    output int                                words_pending,
    output int                                words_checked,
    output int                                rows_checked
);
    import pvszr_pkg::*;

    typedef struct packed {
        word_t  word;
        count_t count;
        logic   last;
    } vis_word_t;

    // Expected output words, oldest first.
    vis_word_t expected_words[$];

    // Shadow of the decompressor's row state.
    cfg_t  row_len;
    bit    count_due;
    word_t word_acc;
    int    fill;
    int    done_bytes;

    function automatic int row_limit();
        int r = int'(row_len);
        if (r == 0)
            r = 1;
        if (r > MAX_ROW)
            r = MAX_ROW;
        return r;
    endfunction

    // Adds one byte to the row; returns 1 when that byte closed the row.
    function automatic bit add_row_byte(byte_t b);
        bit row_end;
        vis_word_t entry;
        word_acc[fill*8 +: 8] = b;
        fill++;
        done_bytes++;
        row_end = done_bytes >= row_limit();
        if (fill >= WORD_BYTES || row_end)
        begin
            entry = '{word_acc, count_t'(fill), row_end};
            expected_words.insert(expected_words.size(), entry);
            word_acc = '0;
            fill     = 0;
        end
        if (row_end)
        begin
            done_bytes = 0;
            count_due  = 1'b0;
        end
        return row_end;
    endfunction

    // Expands one compressed byte into the words it is expected to produce.
    task automatic expand_byte(input byte_t b);
        int c;
        if (count_due)
        begin
            count_due = 1'b0;
            for (c = 0; c < int'(b); c++)
                if (add_row_byte('0))
                    break;
        end
        else if (b == '0)
            count_due = 1'b1;
        else
            void'(add_row_byte(b));
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("checker: %s mismatch, got %h, expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        vis_word_t want;
        if (!rst_n)
        begin
            row_len       = ROW_BYTES_RST;
            count_due     = 1'b0;
            word_acc      = '0;
            fill          = 0;
            done_bytes    = 0;
            errors        = 0;
            expected_words.delete();
            words_pending <= 0;
            words_checked <= 0;
            rows_checked  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_len = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expand_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata[WORD_W-1:0], '0);
                else
                begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata[WORD_W-1:0] !== want.word)
                        report_mismatch("vis_word", m_axis_tdata[WORD_W-1:0], want.word);
                    if (m_axis_tdata[WORD_W +: COUNT_W] !== want.count)
                        report_mismatch("byte_count", word_t'(m_axis_tdata[WORD_W +: COUNT_W]),
                                        word_t'(want.count));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_row", word_t'(m_axis_tlast), word_t'(want.last));
                    if (want.last)
                        rows_checked <= rows_checked + 1;
                end
                words_checked <= words_checked + 1;
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

@@ test/tb.sv @@
// Top of the zero-run decompressor testbench: clock, reset, stimulus, back-pressure and verdict.
module tb;
    import pvszr_pkg::*;

    // Cycles allowed for a run of up to 33 words to drain after its last word is expected.
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold-off that forces the block to stall its input.
    localparam int HOLD_CYCLES   = 300;
    // Number of random phases, one per planned row length; 2047 sits above the maximum and 1 is the minimum.
    localparam int PHASES        = 8;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    cfg_t                   cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    byte_t                  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int errors;
    int words_pending;
    int words_checked;
    int rows_checked;

    // Sender bookkeeping: requests left in the current burst and requests accepted so far.
    int bytes_left_in_burst = 0;
    int bytes_sent          = 0;
    // The stimulus raises this to ask the receiver for one long hold-off.
    int hold_asks           = 0;

    cfg_t row_plan [PHASES] = '{cfg_t'(8), cfg_t'(1), cfg_t'(17), cfg_t'(1024),
                                cfg_t'(5), cfg_t'(2047), cfg_t'(64), cfg_t'(200)};

    pvs_zero_run_decompress_top #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),      // in_byte [7:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),      // vis_word [63:0], byte_count [67:64], pad [71:68]
        .m_axis_tlast  (m_axis_tlast)       // last_of_row
    );

    pvs_vis_checker #(
        .MAX_ROW (MAX_ROW_BYTES_DEF)
    ) vis_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .rows_checked  (rows_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one compressed byte and waits until the block takes the request. Bursts of
    // random length are separated by short random gaps; a burst length of zero is never
    // drawn, so long bursts give stretches with no idling at all.
    task automatic send_byte(input byte_t b);
        if (bytes_left_in_burst == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            bytes_left_in_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                               : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_left_in_burst--;
        bytes_sent++;
    endtask

    // Stops offering requests and waits until every expected word has come back. A trailing
    // marker produces nothing, and a long zero run may still be expanding, so a settling
    // stretch follows before anything else touches the block.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        bytes_left_in_burst = 0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes row_bytes once the block is idle. The row itself may be only partly produced.
    task automatic write_row_bytes(input cfg_t row_len);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= row_len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly literal bytes and marker/count pairs. Counts are usually short so rows fill at
    // a sensible pace, with the occasional long run that crosses word and row boundaries.
    task automatic send_random_stream(input int units);
        int k;
        for (k = 0; k < units; k++)
        begin
            if ($urandom_range(0, 9) < 6)
                send_byte(byte_t'($urandom_range(1, 255)));
            else
            begin
                send_byte('0);
                if ($urandom_range(0, 4) == 0)
                    send_byte(byte_t'($urandom_range(0, 255)));
                else
                    send_byte(byte_t'($urandom_range(0, 24)));
            end
        end
        // Now and then leave a marker dangling across the next register write.
        if ($urandom_range(0, 3) == 0)
            send_byte('0);
    endtask

    // Receiver: a stall pattern of its own whose character is redrawn at random,
    // plus one long hold-off when the stimulus asks for it.
    initial
    begin : receiver
        int mode;
        int cycles_left;
        int tick;
        int hold_seen;
        mode        = 0;
        cycles_left = 0;
        tick        = 0;
        hold_seen   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (cycles_left == 0)
            begin
                mode        = $urandom_range(0, 3);
                cycles_left = $urandom_range(16, 96);
            end
            cycles_left--;
            tick++;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ((tick % 5) != 4);
            endcase
        end
    end

    initial
    begin : stimulus
        int p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Bit extremes of literals at the reset row length of 1024.
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        // Shrink the row to what has already been produced: the next byte closes it.
        write_row_bytes(cfg_t'(3));
        send_byte(8'h7F);
        // A marker with a zero count yields nothing.
        send_byte(8'h00);
        send_byte(8'h00);
        // A run of 255 is clipped at the row end and the excess is dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Literal, one-byte run and literal fill a row exactly.
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h55);
        // A row length of zero behaves as one byte per row.
        write_row_bytes(cfg_t'(0));
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h02);
        // Above the maximum the row is held at 1024; long runs give many full words.
        write_row_bytes(cfg_t'(2047));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);

        // Random part, one phase per row length. The phase with row length 1024 also carries the
        // receiver hold-off, so the block fills up and stops taking requests.
        for (p = 0; p < PHASES; p++)
        begin
            write_row_bytes(row_plan[p]);
            if (row_plan[p] == cfg_t'(1024))
                hold_asks++;
            send_random_stream(8);
        end

        wait_until_drained();
        $display("tb: %0d compressed bytes sent, %0d words and %0d complete rows checked",
                 bytes_sent, words_checked, rows_checked);
        $display("tb: row lengths from 0 to 2047, with stalls on both sides and a long hold-off");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3600000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
